// ===== src/tmw_pkg.sv =====
// Shared types, constants and functions for index folding and entry building in the tilemap entry writer.
package tmw_pkg;

  // Fixed field widths.
  localparam int unsigned ENTRY_W   = 16;
  localparam int unsigned MAP_IDX_W = 12;
  localparam int unsigned SEL_W     = 5;

  // Opcodes.
  localparam logic OP_SRC = 1'b0;
  localparam logic OP_SEQ = 1'b1;

  // Palette selection codes; values above SEL_KEEP do a raw add.
  localparam logic [SEL_W-1:0] SEL_SET_MAX = 5'd15;
  localparam logic [SEL_W-1:0] SEL_KEEP    = 5'd16;

  // Screen sizes.
  localparam logic [1:0] SIZE_64X64 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the accepted item and its folded index
    logic mem_rd;  // read the old entry at the latched index
    logic commit;  // write the new entry and load the output register
  } tmw_cmd_t;

  // Wrap the cell coordinates to the map size and fold them into the
  // 32x32 screen-block layout.
  function automatic logic [MAP_IDX_W-1:0] fold_index(
    input logic [8:0] cell_x,
    input logic [8:0] cell_y,
    input logic [1:0] size
  );
    logic [5:0] xm;
    logic [6:0] ym;
    xm = cell_x[5:0];
    ym = {1'b0, cell_y[5:0]};
    if (!size[0]) begin
      xm[5] = 1'b0;
    end
    if (!size[1]) begin
      ym[5] = 1'b0;
    end
    // Lower half of a 64x64 map skips the two upper screen blocks.
    if (size == SIZE_64X64 && ym[5]) begin
      ym = ym + 7'd32;
    end
    // Right half of a wide map lives in the next screen block.
    if (size[0] && xm[5]) begin
      xm[5] = 1'b0;
      ym = ym + 7'd32;
    end
    return {ym, xm[4:0]};
  endfunction

  // Build the stored entry from a word, an offset and the palette controls.
  function automatic logic [ENTRY_W-1:0] build_entry(
    input logic [ENTRY_W-1:0] word,
    input logic [SEL_W-1:0]   sel,
    input logic [ENTRY_W-1:0] off,
    input logic [3:0]         padd,
    input logic [ENTRY_W-1:0] old
  );
    logic [ENTRY_W-1:0] w;
    logic [ENTRY_W-1:0] v;
    w = word + off;
    if (sel <= SEL_SET_MAX) begin
      v = {sel[3:0] + padd, w[11:0]};
    end else if (sel == SEL_KEEP) begin
      v = {old[15:12] + padd, old[11:10], w[9:0]};
    end else begin
      v = w + {padd, 12'd0};
    end
    return v;
  endfunction

endpackage

// ===== src/tmw_in_if.sv =====
// Input item channel of the tilemap entry writer.
interface tmw_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic               seq_start;
  logic [8:0]         cell_x;
  logic [8:0]         cell_y;
  logic [15:0]        src_entry;
  logic [4:0]         palette_sel;
  logic signed [15:0] tile_offset;
  logic signed [4:0]  palette_add;
  logic signed [10:0] tile_delta;

  modport source (
    output valid, opcode, seq_start, cell_x, cell_y, src_entry, palette_sel,
           tile_offset, palette_add, tile_delta,
    input  ready
  );
  modport sink (
    input  valid, opcode, seq_start, cell_x, cell_y, src_entry, palette_sel,
           tile_offset, palette_add, tile_delta,
    output ready
  );
endinterface

// ===== src/tmw_out_if.sv =====
// Result item channel of the tilemap entry writer.
interface tmw_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] map_index;
  logic [15:0] entry_value;

  modport source (output valid, map_index, entry_value, input ready);
  modport sink (input valid, map_index, entry_value, output ready);
endinterface

// ===== src/tilemap_entry_writer.sv =====
// Top level of the tilemap entry writer: channels, configuration port and submodules.
//
// Each input item writes one 16-bit text-mode entry into an internal map of
// MAP_ENTRIES words and returns the index and value written as one result
// item. An item is accepted only while the block is idle. In the accepting
// cycle its coordinates are folded, and it is latched at the accepting edge.
// The next cycle does the registered read of the old entry from the map
// memory. The build state then builds and writes the new entry and loads
// the result register. No new item is taken until the current one has
// been written. The build state waits as long as an earlier result is
// still waiting in the result register. Map entries are undefined until
// written; keep-palette writes must target entries written before.
// screen_size is written through cfg_we and cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce.
module tilemap_entry_writer
  import tmw_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  tmw_in_if.sink     in_ch,
  tmw_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  tmw_cmd_t cmd;

  // Sequencing of each item.
  tmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Index folding, map storage and entry building.
  tmw_dp #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .opcode      (in_ch.opcode),
    .seq_start   (in_ch.seq_start),
    .cell_x      (in_ch.cell_x),
    .cell_y      (in_ch.cell_y),
    .src_entry   (in_ch.src_entry),
    .palette_sel (in_ch.palette_sel),
    .tile_offset (in_ch.tile_offset),
    .palette_add (in_ch.palette_add),
    .tile_delta  (in_ch.tile_delta),
    .map_index   (out_ch.map_index),
    .entry_value (out_ch.entry_value)
  );

endmodule

// ===== src/tmw_ctrl.sv =====
// Controller state machine that sequences accept, map read and commit of each item.
module tmw_ctrl
  import tmw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tmw_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_BUILD = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  // The output register can take a new item when empty or being drained.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.mem_rd = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_BUILD;
      end
      ST_BUILD: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag follows commits and downstream accepts.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/tmw_dp.sv =====
// Datapath: configuration and item registers, index folding, map memory, entry building and output register.
module tmw_dp
  import tmw_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tmw_cmd_t              cmd,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  input  logic                  opcode,
  input  logic                  seq_start,
  input  logic [8:0]            cell_x,
  input  logic [8:0]            cell_y,
  input  logic [ENTRY_W-1:0]    src_entry,
  input  logic [SEL_W-1:0]      palette_sel,
  input  logic signed [15:0]    tile_offset,
  input  logic signed [4:0]     palette_add,
  input  logic signed [10:0]    tile_delta,
  output logic [MAP_IDX_W-1:0]  map_index,
  output logic [ENTRY_W-1:0]    entry_value
);

  localparam int unsigned AW = $clog2(MAP_ENTRIES);
  localparam logic [MAP_IDX_W+1:0] ONE_M = (MAP_IDX_W+2)'(MAP_ENTRIES);
  localparam logic [MAP_IDX_W+1:0] TWO_M = (MAP_IDX_W+2)'(2 * MAP_ENTRIES);

  logic [1:0]           size_r;
  logic                 op_r;
  logic                 start_r;
  logic [ENTRY_W-1:0]   src_r;
  logic [SEL_W-1:0]     sel_r;
  logic [ENTRY_W-1:0]   off_r;
  logic [3:0]           padd_r;
  logic [9:0]           delta_r;
  logic [AW-1:0]        idx_r;
  logic [ENTRY_W-1:0]   rd_r;
  logic [ENTRY_W-1:0]   run_r;
  logic [ENTRY_W-1:0]   run_nxt;
  logic [MAP_IDX_W-1:0] out_idx_r;
  logic [ENTRY_W-1:0]   out_val_r;

  logic [MAP_IDX_W+1:0] idx_fold;
  logic [MAP_IDX_W+1:0] idx_half;
  logic [MAP_IDX_W+1:0] idx_wrap;
  logic [ENTRY_W-1:0]   word;
  logic [ENTRY_W-1:0]   word_off;
  logic [3:0]           word_padd;
  logic [ENTRY_W-1:0]   new_entry;

  logic [ENTRY_W-1:0]   tile_map [MAP_ENTRIES];

  // Fold the coordinates, then wrap into the map store; the folded index is
  // below 4096, so two compare-and-subtract steps do for MAP_ENTRIES >= 1024.
  always_comb begin
    idx_fold = {2'b00, fold_index(cell_x, cell_y, size_r)};
    idx_half = (idx_fold >= TWO_M) ? idx_fold - TWO_M : idx_fold;
    idx_wrap = (idx_half >= ONE_M) ? idx_half - ONE_M : idx_half;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 2'd0;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode;
      start_r <= seq_start;
      src_r   <= src_entry;
      sel_r   <= palette_sel;
      off_r   <= tile_offset;
      padd_r  <= palette_add[3:0];
      delta_r <= tile_delta[9:0];
      idx_r   <= idx_wrap[AW-1:0];
    end
  end

  // Sequence items write the source word on a start, else the running word; no offset or palette add.
  always_comb begin
    if (op_r == OP_SEQ) begin
      word      = start_r ? src_r : run_r;
      word_off  = '0;
      word_padd = '0;
    end else begin
      word      = src_r;
      word_off  = off_r;
      word_padd = padd_r;
    end
    new_entry = build_entry(word, sel_r, word_off, word_padd, rd_r);
    run_nxt   = {word[15:10], word[9:0] + delta_r};
  end

  // Running tile word steps after each sequence write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (cmd.commit && op_r == OP_SEQ) begin
      run_r <= run_nxt;
    end
  end

  // Map memory: registered read of the old entry, write on commit.
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_r <= tile_map[idx_r];
    end
    if (cmd.commit) begin
      tile_map[idx_r] <= new_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_idx_r <= MAP_IDX_W'(idx_r);
      out_val_r <= new_entry;
    end
  end

  assign map_index   = out_idx_r;
  assign entry_value = out_val_r;

endmodule
